[hw/rtl/gstp_pkg.sv]
package gstp_pkg;

  // Default nesting limit for brace blocks.
  localparam int unsigned MaxNestDefault = 255;

  // Widths of the item fields.
  localparam int unsigned KindW   = 4;
  localparam int unsigned HandleW = 16;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned DepthW  = 8;

  // Token kinds on the input side.
  typedef enum logic [KindW-1:0] {
    K_NT    = 4'd0,
    K_DEF   = 4'd1,
    K_TOK   = 4'd2,
    K_OPEN  = 4'd3,
    K_CLOSE = 4'd4,
    K_OR    = 4'd5,
    K_SPACE = 4'd6,
    K_PAD   = 4'd7,
    K_END   = 4'd8,
    K_NL    = 4'd9
  } kind_e;

  // Event codes on the output side.
  typedef enum logic [CodeW-1:0] {
    E_NEWNT   = 3'd0,
    E_NEWPROD = 3'd1,
    E_PTOK    = 3'd2,
    E_NEWBLK  = 3'd3,
    E_BTOK    = 3'd4,
    E_DROP    = 3'd5,
    E_ACC     = 3'd6,
    E_ERR     = 3'd7
  } event_e;

  // Grammar positions.
  typedef enum logic [3:0] {
    P_RULES = 4'd0,
    P_DEFINE = 4'd1,
    P_ALTS  = 4'd2,
    P_TAIL  = 4'd3,
    P_TAIL2 = 4'd4,
    P_TAIL3 = 4'd5,
    P_MORE  = 4'd6,
    P_BLK_A = 4'd7,
    P_PAD_A = 4'd8,
    P_TOK_A = 4'd9,
    P_BLK_B = 4'd10,
    P_DONE  = 4'd11,
    P_ERROR = 4'd12
  } pos_e;

  // Events caused by one token: one or two codes.
  typedef struct packed {
    logic   two;
    event_e code0;
    event_e code1;
  } step_t;

endpackage

[hw/rtl/grammar_spec_token_parser.sv]
// Grammar-checking token parser. Each input item is one lexical token (kind
// and handle); the block checks the token stream against the production-rule
// grammar and emits one event item per token, or two when a token opens a
// new alternative (new production followed by production token or new block).
// tlast marks the final event of a token. A token waits in the input register
// and is then decoded into the result register, so single-event tokens flow
// at one item per cycle unless the output stalls; a two-event token holds the
// result register until both events are taken, which bounds the rate. Errors
// stick until reset; after the end token every further token is dropped.
module grammar_spec_token_parser #(
  parameter int unsigned MaxNest = gstp_pkg::MaxNestDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [gstp_pkg::HandleW-1:0]   s_axis_tdata,  // token_handle
  input  logic [gstp_pkg::KindW-1:0]     s_axis_tuser,  // token_kind
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [gstp_pkg::HandleW-1:0]   m_axis_tdata,  // event_handle
  output logic [gstp_pkg::CodeW-1:0]     m_axis_tuser,  // event_code
  output logic                           m_axis_tlast   // last_event
);
  import gstp_pkg::*;

  logic               in_valid_q;
  logic [KindW-1:0]   in_kind_q;
  logic [HandleW-1:0] in_handle_q;

  logic               res_valid_q;
  logic               res_idx_q;
  step_t              res_step_q;
  logic [HandleW-1:0] res_handle_q;

  step_t step;
  logic  res_pop, res_free, move, s_acc, m_acc;

  // Handshake and stage movement.
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_acc         = m_axis_tvalid && m_axis_tready;
  assign res_pop       = m_acc && m_axis_tlast;
  assign res_free      = !res_valid_q || res_pop;
  assign move          = in_valid_q && res_free;
  assign s_axis_tready = !in_valid_q || res_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_acc) begin
      in_valid_q <= 1'b1;
    end else if (move) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_kind_q   <= s_axis_tuser;
      in_handle_q <= s_axis_tdata;
    end
  end

  // Grammar decoder with the parse state.
  gstp_parser #(
    .MaxNest(MaxNest)
  ) u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(move),
    .kind_i(in_kind_q),
    .step_o(step)
  );

  // Result register; res_idx_q selects the event currently shown.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_idx_q   <= 1'b0;
    end else if (move) begin
      res_valid_q <= 1'b1;
      res_idx_q   <= 1'b0;
    end else if (res_pop) begin
      res_valid_q <= 1'b0;
    end else if (m_acc) begin
      res_idx_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      res_step_q   <= step;
      res_handle_q <= in_handle_q;
    end
  end

  // Output item.
  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tlast  = !res_step_q.two || res_idx_q;
  assign m_axis_tdata  = res_handle_q;
  assign m_axis_tuser  = res_idx_q ? res_step_q.code1 : res_step_q.code0;

endmodule

[hw/rtl/gstp_parser.sv]
module gstp_parser #(
  parameter int unsigned MaxNest = gstp_pkg::MaxNestDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [gstp_pkg::KindW-1:0]     kind_i,
  output gstp_pkg::step_t                step_o
);
  import gstp_pkg::*;

  // Effective nesting limit, capped by the depth counter range.
  localparam logic [DepthW-1:0] NestLimit =
    (MaxNest < 255) ? DepthW'(MaxNest) : DepthW'(255);

  pos_e              pos_q, pos_d;
  logic [DepthW-1:0] dep_q, dep_d;

  // Outcome of the rule-level choice.
  event_e rules_code;
  pos_e   rules_pos;
  always_comb begin
    rules_code = E_ERR;
    rules_pos  = P_ERROR;
    if (kind_i == K_NT) begin
      rules_code = E_NEWNT;
      rules_pos  = P_DEFINE;
    end else if (kind_i == K_END) begin
      rules_code = E_ACC;
      rules_pos  = P_DONE;
    end
  end

  // Outcome of the "more symbols" choice.
  event_e more_code;
  pos_e   more_pos;
  always_comb begin
    more_code = E_ERR;
    more_pos  = P_ERROR;
    if (kind_i == K_TOK) begin
      more_code = E_PTOK;
      more_pos  = P_TAIL;
    end else if (kind_i == K_OR) begin
      more_code = E_DROP;
      more_pos  = P_ALTS;
    end
  end

  // Outcome inside a brace block; the closing brace at depth one leaves the block.
  event_e            blk_code;
  logic              blk_exit;
  logic [DepthW-1:0] blk_dep;
  always_comb begin
    blk_code = E_BTOK;
    blk_exit = 1'b0;
    blk_dep  = dep_q;
    if (kind_i == K_END || kind_i > K_NL) begin
      blk_code = E_ERR;
    end else if (kind_i == K_CLOSE) begin
      if (dep_q <= DepthW'(1)) begin
        blk_code = E_DROP;
        blk_exit = 1'b1;
        blk_dep  = '0;
      end else begin
        blk_dep = dep_q - DepthW'(1);
      end
    end else if (kind_i == K_OPEN) begin
      if (dep_q >= NestLimit) begin
        blk_code = E_ERR;
      end else begin
        blk_dep = dep_q + DepthW'(1);
      end
    end
  end

  // Transition per position; any error code forces the sticky error position.
  always_comb begin
    step_o = '{two: 1'b0, code0: E_ERR, code1: E_ERR};
    pos_d  = P_ERROR;
    dep_d  = dep_q;
    case (pos_q)
      P_RULES: begin
        step_o.code0 = rules_code;
        pos_d        = rules_pos;
      end
      P_DEFINE: begin
        if (kind_i == K_DEF) begin
          step_o.code0 = E_DROP;
          pos_d        = P_ALTS;
        end
      end
      P_ALTS: begin
        if (kind_i == K_TOK) begin
          step_o = '{two: 1'b1, code0: E_NEWPROD, code1: E_PTOK};
          pos_d  = P_TAIL;
        end else if (kind_i == K_OPEN) begin
          step_o = '{two: 1'b1, code0: E_NEWPROD, code1: E_NEWBLK};
          pos_d  = P_BLK_A;
          dep_d  = DepthW'(1);
        end
      end
      P_TAIL, P_TAIL3: begin
        if (kind_i == K_PAD) begin
          step_o.code0 = E_DROP;
          pos_d        = P_MORE;
        end else if (kind_i == K_SPACE && pos_q == P_TAIL) begin
          step_o.code0 = E_DROP;
          pos_d        = P_TAIL2;
        end else if (kind_i == K_NT || kind_i == K_END) begin
          step_o.code0 = rules_code;
          pos_d        = rules_pos;
        end
      end
      P_TAIL2: begin
        if (kind_i == K_OPEN) begin
          step_o.code0 = E_NEWBLK;
          pos_d        = P_BLK_B;
          dep_d        = DepthW'(1);
        end else begin
          step_o.code0 = more_code;
          pos_d        = more_pos;
        end
      end
      P_MORE: begin
        step_o.code0 = more_code;
        pos_d        = more_pos;
      end
      P_BLK_A, P_BLK_B: begin
        step_o.code0 = blk_code;
        dep_d        = blk_dep;
        if (blk_exit) begin
          pos_d = (pos_q == P_BLK_A) ? P_PAD_A : P_TAIL3;
        end else begin
          pos_d = pos_q;
        end
      end
      P_PAD_A: begin
        if (kind_i == K_PAD) begin
          step_o.code0 = E_DROP;
          pos_d        = P_TOK_A;
        end
      end
      P_TOK_A: begin
        if (kind_i == K_TOK) begin
          step_o.code0 = E_PTOK;
          pos_d        = P_TAIL;
        end
      end
      P_DONE: begin
        step_o.code0 = E_DROP;
        pos_d        = P_DONE;
      end
      default: begin
        step_o.code0 = E_ERR;
      end
    endcase
    if (step_o.code0 == E_ERR) begin
      pos_d = P_ERROR;
      dep_d = '0;
    end
  end

  // Parse position and brace depth advance once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= P_RULES;
      dep_q <= '0;
    end else if (step_i) begin
      pos_q <= pos_d;
      dep_q <= dep_d;
    end
  end

endmodule

[hw/rtl/gstp_checker.sv]
module gstp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [gstp_pkg::HandleW-1:0] m_axis_tdata,
  input logic [gstp_pkg::CodeW-1:0]   m_axis_tuser,
  input logic                         m_axis_tlast
);
  import gstp_pkg::*;

  // A stalled output item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // Only a new production opens a two-event token.
  a_first_of_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == E_NEWPROD)
    else $error("non-final event is not a new production");

  // The second event follows at once, for the same token.
  a_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tlast && (m_axis_tuser == E_PTOK || m_axis_tuser == E_NEWBLK)
      && $stable(m_axis_tdata))
    else $error("second event of a token is wrong");

  // An error is always the only event of its token.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == E_ERR |-> m_axis_tlast)
    else $error("error event not final");

  // A valid output item and the input ready carry no unknown bits.
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !$isunknown({m_axis_tuser, m_axis_tdata, m_axis_tlast})
      && !$isunknown(s_axis_tready))
    else $error("output item has unknown bits");

endmodule

bind grammar_spec_token_parser gstp_checker u_gstp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

[tb/grammar_spec_token_parser_test.sv]
module grammar_spec_token_parser_test;
  import gstp_pkg::*;

  // Nesting limit that the block applies with its default parameter.
  localparam int unsigned NestLimit = (MaxNestDefault < 255) ? MaxNestDefault : 255;

  // How the run ends: every ending except acceptance leaves the parser stuck in error.
  typedef enum int {
    FIN_OVERFLOW,
    FIN_IN_BLOCK,
    FIN_NL_OUTSIDE,
    FIN_BAD_KIND,
    FIN_UNEXPECTED,
    FIN_ACCEPT
  } wrap_up_e;

  // One expected event item.
  typedef struct packed {
    event_e            code;
    logic [HandleW-1:0] handle;
    logic              last;
  } event_rec_t;

  // One row of the directed token table.
  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [HandleW-1:0] handle;
    logic               typed;
    step_t              want;
  } token_row_t;

  localparam int unsigned NumRows = 26;

  // A well-formed opening: every grammar position, nested braces and block content.
  localparam token_row_t DirectedRows [NumRows] = '{
    '{K_NT,    16'h0000, 1'b1, '{1'b0, E_NEWNT,   E_ERR}},
    '{K_DEF,   16'hFFFF, 1'b1, '{1'b0, E_DROP,    E_ERR}},
    '{K_TOK,   16'h8001, 1'b1, '{1'b1, E_NEWPROD, E_PTOK}},
    '{K_SPACE, 16'h1234, 1'b0, '0},
    '{K_TOK,   16'h0001, 1'b0, '0},
    '{K_PAD,   16'h7FFE, 1'b0, '0},
    '{K_OR,    16'h5555, 1'b0, '0},
    '{K_OPEN,  16'hAAAA, 1'b1, '{1'b1, E_NEWPROD, E_NEWBLK}},
    '{K_OPEN,  16'h00FF, 1'b0, '0},
    '{K_NL,    16'hFF00, 1'b0, '0},
    '{K_NT,    16'h0F0F, 1'b0, '0},
    '{K_DEF,   16'hF0F0, 1'b0, '0},
    '{K_CLOSE, 16'h3C3C, 1'b0, '0},
    '{K_CLOSE, 16'hC3C3, 1'b0, '0},
    '{K_PAD,   16'h0002, 1'b0, '0},
    '{K_TOK,   16'h0004, 1'b0, '0},
    '{K_SPACE, 16'h0008, 1'b0, '0},
    '{K_OPEN,  16'h0010, 1'b0, '0},
    '{K_OR,    16'h0020, 1'b0, '0},
    '{K_CLOSE, 16'h0040, 1'b0, '0},
    '{K_PAD,   16'h0080, 1'b0, '0},
    '{K_TOK,   16'h0100, 1'b0, '0},
    '{K_SPACE, 16'h0200, 1'b0, '0},
    '{K_OR,    16'h0400, 1'b0, '0},
    '{K_TOK,   16'h0800, 1'b0, '0},
    '{K_NT,    16'hFFFF, 1'b1, '{1'b0, E_NEWNT,   E_ERR}}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [HandleW-1:0] s_axis_tdata;
  logic [KindW-1:0]   s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [HandleW-1:0] m_axis_tdata;
  logic [CodeW-1:0]   m_axis_tuser;
  logic               m_axis_tlast;

  // Shadow of the parser state.
  pos_e        pos_q;
  int unsigned depth_q;

  event_rec_t  pending_events [$];
  int unsigned mismatch_count;
  int unsigned results_seen;
  bit          quiet;

  grammar_spec_token_parser #(
    .MaxNest(MaxNestDefault)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic step_t one_event(event_e code);
    return '{1'b0, code, E_ERR};
  endfunction

  // Any grammar violation parks the parser in the sticky error position.
  function automatic step_t enter_error();
    pos_q   = P_ERROR;
    depth_q = 0;
    return one_event(E_ERR);
  endfunction

  function automatic step_t rule_level(logic [KindW-1:0] kind);
    if (kind == K_NT) begin
      pos_q = P_DEFINE;
      return one_event(E_NEWNT);
    end
    if (kind == K_END) begin
      pos_q = P_DONE;
      return one_event(E_ACC);
    end
    return enter_error();
  endfunction

  function automatic step_t alt_more(logic [KindW-1:0] kind);
    if (kind == K_TOK) begin
      pos_q = P_TAIL;
      return one_event(E_PTOK);
    end
    if (kind == K_OR) begin
      pos_q = P_ALTS;
      return one_event(E_DROP);
    end
    return enter_error();
  endfunction

  // In braces: end, bad kind or overflow errs; outer close dropped; rest copied.
  function automatic step_t block_body(logic [KindW-1:0] kind, pos_e after);
    if (kind == K_END || kind > K_NL) begin
      return enter_error();
    end
    if (kind == K_CLOSE) begin
      if (depth_q <= 1) begin
        depth_q = 0;
        pos_q   = after;
        return one_event(E_DROP);
      end
      depth_q--;
      return one_event(E_BTOK);
    end
    if (kind == K_OPEN) begin
      if (depth_q >= NestLimit) begin
        return enter_error();
      end
      depth_q++;
    end
    return one_event(E_BTOK);
  endfunction

  // Events caused by one token, advancing the shadow state.
  function automatic step_t parse_step(logic [KindW-1:0] kind);
    case (pos_q)
      P_RULES: return rule_level(kind);
      P_DEFINE: begin
        if (kind != K_DEF) return enter_error();
        pos_q = P_ALTS;
        return one_event(E_DROP);
      end
      P_ALTS: begin
        if (kind == K_TOK) begin
          pos_q = P_TAIL;
          return '{1'b1, E_NEWPROD, E_PTOK};
        end
        if (kind == K_OPEN) begin
          depth_q = 1;
          pos_q   = P_BLK_A;
          return '{1'b1, E_NEWPROD, E_NEWBLK};
        end
        return enter_error();
      end
      P_TAIL: begin
        if (kind == K_SPACE) begin
          pos_q = P_TAIL2;
          return one_event(E_DROP);
        end
        if (kind == K_PAD) begin
          pos_q = P_MORE;
          return one_event(E_DROP);
        end
        if (kind == K_NT || kind == K_END) return rule_level(kind);
        return enter_error();
      end
      P_TAIL2: begin
        if (kind == K_OPEN) begin
          depth_q = 1;
          pos_q   = P_BLK_B;
          return one_event(E_NEWBLK);
        end
        return alt_more(kind);
      end
      P_TAIL3: begin
        if (kind == K_PAD) begin
          pos_q = P_MORE;
          return one_event(E_DROP);
        end
        if (kind == K_NT || kind == K_END) return rule_level(kind);
        return enter_error();
      end
      P_MORE: return alt_more(kind);
      P_BLK_A: return block_body(kind, P_PAD_A);
      P_PAD_A: begin
        if (kind != K_PAD) return enter_error();
        pos_q = P_TOK_A;
        return one_event(E_DROP);
      end
      P_TOK_A: begin
        if (kind != K_TOK) return enter_error();
        pos_q = P_TAIL;
        return one_event(E_PTOK);
      end
      P_BLK_B: return block_body(kind, P_TAIL3);
      P_DONE: return one_event(E_DROP);
      default: return enter_error();
    endcase
  endfunction

  // Random token that the grammar accepts in the current position.
  function automatic logic [KindW-1:0] pick_legal();
    int unsigned r;
    logic [KindW-1:0] k;
    r = $urandom_range(0, 9);
    k = K_NT;
    case (pos_q)
      P_RULES:  k = K_NT;
      P_DEFINE: k = K_DEF;
      P_ALTS:   k = (r < 5) ? K_TOK : K_OPEN;
      P_TAIL:   k = (r < 2) ? K_NT : ((r < 6) ? K_SPACE : K_PAD);
      P_TAIL2:  k = (r < 4) ? K_OPEN : ((r < 7) ? K_TOK : K_OR);
      P_TAIL3:  k = (r < 3) ? K_NT : K_PAD;
      P_MORE:   k = (r < 6) ? K_TOK : K_OR;
      P_BLK_A, P_BLK_B: begin
        // Closing is favored so that blocks stay shallow.
        if (r < 3 || (r < 5 && depth_q >= 6)) begin
          k = K_CLOSE;
        end else if (r < 5) begin
          k = K_OPEN;
        end else begin
          do k = 4'($urandom_range(0, 9));
          while (k == K_END || k == K_OPEN || k == K_CLOSE);
        end
      end
      P_PAD_A:  k = K_PAD;
      P_TOK_A:  k = K_TOK;
      default:  k = K_NT;
    endcase
    return k;
  endfunction

  function automatic bit in_block();
    return pos_q == P_BLK_A || pos_q == P_BLK_B;
  endfunction

  // Offer one token, wait for its handshake, then queue the events it causes.
  task automatic send_token(input logic [KindW-1:0] kind, input logic [HandleW-1:0] handle,
                            input logic typed, input step_t want);
    step_t step;
    if (!quiet && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= handle;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    step = parse_step(kind);
    if (typed) step = want;
    if (step.two) pending_events.push_back('{step.code0, handle, 1'b0});
    pending_events.push_back('{step.two ? step.code1 : step.code0, handle, 1'b1});
  endtask

  // Result side: random stalls, plus one long hold-off once traffic is flowing.
  initial begin : result_side
    bit held;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= 400) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 6);
    end
  end

  // Compare each accepted event item with the oldest expectation.
  always @(posedge clk_i) begin : check_events
    event_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_events.size() == 0) begin
        mismatch_count++;
        $display("%0t: event with none expected: code %0d handle %h last %b", $time,
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tuser != want.code || m_axis_tdata != want.handle ||
            m_axis_tlast != want.last) begin
          mismatch_count++;
          $display("%0t: expected code %0d handle %h last %b, got code %0d handle %h last %b",
                   $time, want.code, want.handle, want.last,
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  initial begin : token_side
    int n;
    wrap_up_e fin;
    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tuser   <= '0;
    quiet          = 1'b0;
    mismatch_count = 0;
    results_seen   = 0;
    pos_q          = P_RULES;
    depth_q        = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening.
    for (n = 0; n < NumRows; n++) begin
      send_token(DirectedRows[n].kind, DirectedRows[n].handle, DirectedRows[n].typed,
                 DirectedRows[n].want);
    end

    // Random well-formed rules with random block content.
    for (n = 0; n < 1800; n++) begin
      quiet = (n >= 1100 && n < 1400);
      if (n == 900) begin
        // Let the block drain completely before going on.
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending_events.size() != 0);
      end
      send_token(pick_legal(), 16'($urandom_range(0, 65535)), 1'b0, '0);
    end
    quiet = 1'b0;

    // One sticky ending, chosen at random, then random tokens of any kind after it.
    fin = wrap_up_e'($urandom_range(0, 5));
    case (fin)
      FIN_OVERFLOW, FIN_IN_BLOCK: begin
        while (!in_block()) send_token(pick_legal(), 16'($urandom_range(0, 65535)), 1'b0, '0);
        if (fin == FIN_OVERFLOW) begin
          while (pos_q != P_ERROR) send_token(K_OPEN, 16'($urandom_range(0, 65535)), 1'b0, '0);
        end else begin
          send_token(K_END, 16'($urandom_range(0, 65535)), 1'b0, '0);
        end
      end
      FIN_NL_OUTSIDE, FIN_UNEXPECTED: begin
        while (in_block()) send_token(pick_legal(), 16'($urandom_range(0, 65535)), 1'b0, '0);
        send_token((fin == FIN_NL_OUTSIDE) ? K_NL : K_CLOSE, 16'($urandom_range(0, 65535)),
                   1'b0, '0);
      end
      FIN_BAD_KIND: begin
        send_token(4'($urandom_range(10, 15)), 16'($urandom_range(0, 65535)), 1'b0, '0);
      end
      default: begin
        while (!(pos_q == P_RULES || pos_q == P_TAIL || pos_q == P_TAIL3)) begin
          send_token(pick_legal(), 16'($urandom_range(0, 65535)), 1'b0, '0);
        end
        send_token(K_END, 16'($urandom_range(0, 65535)), 1'b0, '0);
      end
    endcase
    for (n = 0; n < 20; n++) begin
      send_token(4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    // Wait for the last events, then watch a little longer for strays.
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
